### hdl/mmch_pkg.sv
`default_nettype none
package mmch_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned ScaleFracBits = 12;
  localparam int unsigned RunSteps = (CordicSteps > 24) ? 24 : CordicSteps;

  localparam int unsigned InW = 17;
  localparam int unsigned OutW = 18;
  localparam int unsigned HeadW = 15;
  localparam int unsigned ScaleW = 4 + ScaleFracBits;
  localparam int unsigned StepW = 5;

  // cordic vector width: 18-bit value << 16 plus growth
  localparam int unsigned VecW = 38;
  localparam int unsigned AngW = 24;

  localparam logic signed [OutW-1:0] MinReset = OutW'(1000);
  localparam logic signed [OutW-1:0] MaxReset = -OutW'(1000);
  localparam logic signed [AngW-1:0] Angle180 = AngW'(2949120);
  localparam int HeadLimit = 11520;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAN,
    ST_DIV_START,
    ST_DIV,
    ST_MUL,
    ST_NEXT_AXIS,
    ST_CORDIC_INIT,
    ST_CORDIC,
    ST_DONE
  } state_e;

  // control from sequencer to cordic/divider
  typedef struct packed {
    logic start;
    logic step;
  } unit_ctrl_t;

  // atan(2^-i) in units of 2^-14 degree
  function automatic logic [AngW-1:0] atan_lut(input logic [StepW-1:0] i);
    logic [AngW-1:0] r;
    unique case (i)
      5'd0: r = AngW'(737280);
      5'd1: r = AngW'(435242);
      5'd2: r = AngW'(229970);
      5'd3: r = AngW'(116736);
      5'd4: r = AngW'(58595);
      5'd5: r = AngW'(29326);
      5'd6: r = AngW'(14667);
      5'd7: r = AngW'(7334);
      5'd8: r = AngW'(3667);
      5'd9: r = AngW'(1833);
      5'd10: r = AngW'(917);
      5'd11: r = AngW'(458);
      5'd12: r = AngW'(229);
      5'd13: r = AngW'(115);
      5'd14: r = AngW'(57);
      5'd15: r = AngW'(29);
      5'd16: r = AngW'(14);
      5'd17: r = AngW'(7);
      5'd18: r = AngW'(4);
      5'd19: r = AngW'(2);
      5'd20: r = AngW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/mmch_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle while step is asserted
// quotient = floor(num * 2^frac / den), num < 2^19, saturated to scale range
module mmch_div (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire mmch_pkg::unit_ctrl_t ctrl_i,
  input  wire logic [18:0] num_i,
  input  wire logic [18:0] den_i,
  output logic done_o,
  output logic [mmch_pkg::ScaleW-1:0] quot_o
);
  localparam int unsigned NumW = 19 + mmch_pkg::ScaleFracBits;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [19:0] rem_q, rem_d;
  logic [18:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [19:0] trial;
  logic [19:0] shifted;

  // one shift-subtract step
  always_comb begin
    num_d = num_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    shifted = {rem_q[18:0], num_q[NumW-1]};
    trial = shifted - {1'b0, den_q};
    if (ctrl_i.start) begin
      num_d = {num_i, {mmch_pkg::ScaleFracBits{1'b0}}};
      den_d = den_i;
      rem_d = '0;
      quo_d = '0;
      cnt_d = CntW'(NumW);
    end else if (ctrl_i.step && cnt_q != '0) begin
      num_d = {num_q[NumW-2:0], 1'b0};
      if (!trial[19]) begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = (cnt_q == '0);
  // saturate at top of scale range
  assign quot_o = (|quo_q[NumW-1:mmch_pkg::ScaleW]) ? '1 : quo_q[mmch_pkg::ScaleW-1:0];
endmodule
`default_nettype wire

### hdl/mmch_cordic.sv
`default_nettype none
// vectoring cordic, one micro-rotation per step
module mmch_cordic (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire mmch_pkg::unit_ctrl_t ctrl_i,
  input  wire logic signed [mmch_pkg::OutW-1:0] x_i,
  input  wire logic signed [mmch_pkg::OutW-1:0] y_i,
  output logic done_o,
  output logic signed [mmch_pkg::HeadW-1:0] heading_o
);
  localparam int unsigned VecW = mmch_pkg::VecW;
  localparam int unsigned AngW = mmch_pkg::AngW;

  logic signed [VecW-1:0] re_q, re_d, im_q, im_d;
  logic signed [AngW-1:0] z_q, z_d;
  logic [mmch_pkg::StepW-1:0] i_q, i_d;
  logic zero_q, zero_d;
  logic busy_q, busy_d;
  logic signed [VecW-1:0] re0, im0, dre, dim;
  logic signed [AngW-1:0] atn, zr;
  logic signed [AngW-9:0] hs;

  always_comb begin
    re_d = re_q;
    im_d = im_q;
    z_d = z_q;
    i_d = i_q;
    zero_d = zero_q;
    busy_d = busy_q;
    re0 = VecW'(y_i) <<< 16;
    im0 = VecW'(x_i) <<< 16;
    dre = im_q >>> i_q;
    dim = re_q >>> i_q;
    atn = $signed(mmch_pkg::atan_lut(i_q));
    if (ctrl_i.start) begin
      zero_d = (x_i == '0) && (y_i == '0);
      i_d = '0;
      busy_d = 1'b1;
      // pre-rotate into right half plane
      if (re0 < 0) begin
        re_d = -re0;
        im_d = -im0;
        z_d = (im0 >= 0) ? mmch_pkg::Angle180 : -mmch_pkg::Angle180;
      end else begin
        re_d = re0;
        im_d = im0;
        z_d = '0;
      end
    end else if (ctrl_i.step && busy_q) begin
      if (im_q > 0) begin
        re_d = re_q + dre;
        im_d = im_q - dim;
        z_d = z_q + atn;
      end else begin
        re_d = re_q - dre;
        im_d = im_q + dim;
        z_d = z_q - atn;
      end
      i_d = i_q + 1'b1;
      if (i_q == mmch_pkg::StepW'(mmch_pkg::RunSteps - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    re_q <= re_d;
    im_q <= im_d;
    z_q <= z_d;
    i_q <= i_d;
    zero_q <= zero_d;
  end

  // round to 1/64 degree and clamp
  always_comb begin
    zr = z_q + AngW'(128);
    hs = zr[AngW-1:8];
    if (zero_q) begin
      heading_o = '0;
    end else if (hs > (AngW-8)'(mmch_pkg::HeadLimit)) begin
      heading_o = mmch_pkg::HeadW'(mmch_pkg::HeadLimit);
    end else if (hs < -(AngW-8)'(mmch_pkg::HeadLimit)) begin
      heading_o = -mmch_pkg::HeadW'(mmch_pkg::HeadLimit);
    end else begin
      heading_o = hs[mmch_pkg::HeadW-1:0];
    end
  end

  assign done_o = !busy_q;
endmodule
`default_nettype wire

### hdl/magnetometer_minmax_calibrate_heading.sv
`default_nettype none
// while learning, a sample goes through the span, cordic init, cordic and done states;
// while correcting, three passes of divide start, a 31-step divide, multiply and next
// axis come between span and cordic init. not ready while a sample is in work.
// the result is held in an output register until transferred; a held result stalls
// the next one in the done state. reset: min/max to 100 uT / -100 uT, correction off
module magnetometer_minmax_calibrate_heading (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_ready_o,
  input  wire logic signed [16:0] mag_x_i,
  input  wire logic signed [16:0] mag_y_i,
  input  wire logic signed [16:0] mag_z_i,
  output logic out_valid_o,
  input  wire logic out_ready_i,
  output logic signed [17:0] out_x_o,
  output logic signed [17:0] out_y_o,
  output logic signed [17:0] out_z_o,
  output logic signed [14:0] heading_o,
  output logic scale_fault_o,
  input  wire logic cfg_we_i,
  input  wire logic cfg_wdata_i
);
  localparam int unsigned OutW = mmch_pkg::OutW;
  localparam int unsigned Fb = mmch_pkg::ScaleFracBits;
  localparam int unsigned PW = 21 + mmch_pkg::ScaleW;

  mmch_pkg::state_e state_q, state_d;
  logic enable_q;
  logic signed [OutW-1:0] min_q [3];
  logic signed [OutW-1:0] max_q [3];
  logic signed [16:0] s_q [3];
  logic signed [OutW-1:0] o_q [3], o_d;
  logic [1:0] ax_q, ax_d;
  logic fault_q, fault_d;
  logic [18:0] span_q [3];
  logic spanbad_q [3];
  logic [18:0] maxspan_q;
  logic [mmch_pkg::ScaleW-1:0] scale;
  logic signed [PW-1:0] prod;
  logic signed [20:0] diff;
  logic signed [PW-Fb-2:0] shq;
  logic signed [OutW-1:0] ox_q, oy_q, oz_q;
  logic signed [mmch_pkg::HeadW-1:0] head_w;
  logic div_done, cor_done;
  logic [mmch_pkg::ScaleW-1:0] quot;
  mmch_pkg::unit_ctrl_t div_ctrl, cor_ctrl;
  logic load, learn, span_en, mul_en, res_en;
  logic signed [18:0] sp [3];
  logic [18:0] msp;

  assign load = in_valid_i && in_ready_o;

  // sequencer
  always_comb begin
    state_d = state_q;
    in_ready_o = 1'b0;
    div_ctrl = '0;
    cor_ctrl = '0;
    learn = 1'b0;
    span_en = 1'b0;
    mul_en = 1'b0;
    res_en = 1'b0;
    ax_d = ax_q;
    unique case (state_q)
      mmch_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        ax_d = '0;
        if (in_valid_i) begin
          state_d = mmch_pkg::ST_SPAN;
        end
      end
      mmch_pkg::ST_SPAN: begin
        if (enable_q) begin
          span_en = 1'b1;
          state_d = mmch_pkg::ST_DIV_START;
        end else begin
          learn = 1'b1;
          state_d = mmch_pkg::ST_CORDIC_INIT;
        end
      end
      mmch_pkg::ST_DIV_START: begin
        div_ctrl.start = 1'b1;
        state_d = mmch_pkg::ST_DIV;
      end
      mmch_pkg::ST_DIV: begin
        div_ctrl.step = 1'b1;
        if (div_done) begin
          state_d = mmch_pkg::ST_MUL;
        end
      end
      mmch_pkg::ST_MUL: begin
        mul_en = 1'b1;
        state_d = mmch_pkg::ST_NEXT_AXIS;
      end
      mmch_pkg::ST_NEXT_AXIS: begin
        if (ax_q == 2'd2) begin
          state_d = mmch_pkg::ST_CORDIC_INIT;
        end else begin
          ax_d = ax_q + 1'b1;
          state_d = mmch_pkg::ST_DIV_START;
        end
      end
      mmch_pkg::ST_CORDIC_INIT: begin
        cor_ctrl.start = 1'b1;
        state_d = mmch_pkg::ST_CORDIC;
      end
      mmch_pkg::ST_CORDIC: begin
        cor_ctrl.step = 1'b1;
        if (cor_done) begin
          res_en = 1'b1;
          state_d = mmch_pkg::ST_DONE;
        end
      end
      mmch_pkg::ST_DONE: begin
        if (!out_valid_o || out_ready_i) begin
          state_d = mmch_pkg::ST_IDLE;
        end
      end
      default: state_d = mmch_pkg::ST_IDLE;
    endcase
  end

  // done state waits for output register free; res_en loads the ox/oy/oz staging registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmch_pkg::ST_IDLE;
      enable_q <= 1'b0;
      out_valid_o <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        min_q[a] <= mmch_pkg::MinReset;
        max_q[a] <= mmch_pkg::MaxReset;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      if (state_q == mmch_pkg::ST_DONE && state_d == mmch_pkg::ST_IDLE) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (learn) begin
        for (int a = 0; a < 3; a++) begin
          if (OutW'(s_q[a]) < min_q[a]) min_q[a] <= OutW'(s_q[a]);
          if (OutW'(s_q[a]) > max_q[a]) max_q[a] <= OutW'(s_q[a]);
        end
      end
    end
  end

  // spans and largest span
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sp[a] = 19'(max_q[a]) - 19'(min_q[a]);
    end
    msp = sp[0];
    if (sp[1] > $signed(msp)) msp = sp[1];
    if (sp[2] > $signed(msp)) msp = sp[2];
  end

  // scale select, multiply, round and saturate for current axis
  always_comb begin
    scale = spanbad_q[ax_q] ? mmch_pkg::ScaleW'(1 << Fb) : quot;
    diff = 21'(s_q[ax_q]) * 21'sd2 - (21'(max_q[ax_q]) + 21'(min_q[ax_q]));
    prod = PW'(diff) * $signed({1'b0, scale}) + PW'(1 << Fb);
    shq = prod[PW-1:Fb+1];
    if (shq > (PW-Fb-1)'(131071)) o_d = 18'sh1ffff;
    else if (shq < -(PW-Fb-1)'(131072)) o_d = -18'sh20000;
    else o_d = shq[OutW-1:0];
    fault_d = fault_q | spanbad_q[ax_q];
  end

  always_ff @(posedge clk_i) begin
    ax_q <= ax_d;
    if (load) begin
      s_q[0] <= mag_x_i;
      s_q[1] <= mag_y_i;
      s_q[2] <= mag_z_i;
      fault_q <= 1'b0;
    end
    if (span_en) begin
      for (int a = 0; a < 3; a++) begin
        span_q[a] <= sp[a];
        spanbad_q[a] <= sp[a][18] || sp[a] == '0;
      end
      maxspan_q <= msp;
    end
    if (learn) begin
      for (int a = 0; a < 3; a++) begin
        o_q[a] <= OutW'(s_q[a]);
      end
    end
    if (mul_en) begin
      o_q[ax_q] <= o_d;
      fault_q <= fault_d;
    end
    if (res_en) begin
      ox_q <= o_q[0];
      oy_q <= o_q[1];
      oz_q <= o_q[2];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (state_q == mmch_pkg::ST_DONE && state_d == mmch_pkg::ST_IDLE) begin
      out_x_o <= ox_q;
      out_y_o <= oy_q;
      out_z_o <= oz_q;
      heading_o <= head_w;
      scale_fault_o <= fault_q;
    end
  end

  mmch_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (maxspan_q),
    .den_i  (span_q[ax_q]),
    .done_o (div_done),
    .quot_o (quot)
  );

  mmch_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (cor_ctrl),
    .x_i       (o_q[0]),
    .y_i       (o_q[1]),
    .done_o    (cor_done),
    .heading_o (head_w)
  );
endmodule
`default_nettype wire
